### rtl/mfs_pkg.sv
// Package for the message frame segmenter: frame geometry, field widths,
// the item kind codes, the per-item sequencing phases and the shared structs.
// No dependencies; every other file refers to it by scoped names.
`default_nettype none

package mfs_pkg;

    // Frame geometry. FRAME_BYTES must be a power of two (frame count is a shift).
    localparam int FRAME_BYTES       = 32;
    localparam int MAX_MESSAGE_BYTES = 65535;
    localparam int HEADER_BYTES      = 5;
    localparam int FOOTER_BYTES      = 1;
    localparam int COUNT_BYTES       = 4;
    localparam int PAYLOAD_CAP       = FRAME_BYTES - HEADER_BYTES;

    // Field widths.
    localparam int BYTE_W      = 8;
    localparam int LEN_W       = 16;
    localparam int SUM_W       = LEN_W + 1;
    localparam int COUNT_W     = BYTE_W * COUNT_BYTES;
    localparam int POS_W       = $clog2(FRAME_BYTES);
    localparam int FRAME_SHIFT = $clog2(FRAME_BYTES);
    localparam int FRAMES_W    =
        $clog2((MAX_MESSAGE_BYTES + HEADER_BYTES + FOOTER_BYTES + FRAME_BYTES - 1)
               / FRAME_BYTES + 1);

    typedef enum logic
    {
        KIND_START = 1'b0,
        KIND_DATA  = 1'b1
    } kind_t;

    // Where the sequencer stands within the run of bytes of one input word.
    typedef enum logic [1:0]
    {
        PH_ENTRY  = 2'd0,
        PH_HEADER = 2'd1,
        PH_LENGTH = 2'd2,
        PH_FILL   = 2'd3
    } phase_t;

    typedef struct packed
    {
        kind_t                    kind;
        logic [LEN_W-1:0]         message_length;
        logic [BYTE_W-1:0]        data_byte;
    } item_t;

    // One step of the sequencer: the byte it produces, if any, and whether
    // the held input word is finished with this step.
    typedef struct packed
    {
        logic                     done;
        logic                     emit;
        logic [BYTE_W-1:0]        value;
        logic                     eof;
    } step_t;

endpackage

`default_nettype wire

### rtl/mfs_if.sv
// Channel interfaces of the message frame segmenter: input words, output
// frame bytes and the fill-byte configuration write. Uses mfs_pkg widths.
`default_nettype none

interface mfs_item_if;
    logic                            valid;
    logic                            ready;
    logic                            kind;
    logic [mfs_pkg::LEN_W-1:0]       message_length;
    logic [mfs_pkg::BYTE_W-1:0]      data_byte;

    modport source (output valid, output kind, output message_length,
                    output data_byte, input ready);
    modport sink   (input valid, input kind, input message_length,
                    input data_byte, output ready);
endinterface

interface mfs_frame_if;
    logic                            valid;
    logic                            ready;
    logic [mfs_pkg::BYTE_W-1:0]      frame_byte;
    logic                            end_of_frame;
    logic                            end_of_run;

    modport source (output valid, output frame_byte, output end_of_frame,
                    output end_of_run, input ready);
    modport sink   (input valid, input frame_byte, input end_of_frame,
                    input end_of_run, output ready);
endinterface

interface mfs_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [mfs_pkg::BYTE_W-1:0]      fill_byte;

    modport source (output valid, output fill_byte, input ready);
    modport sink   (input valid, input fill_byte, output ready);
endinterface

`default_nettype wire

### rtl/mfs_core.sv
// Sequencer of the message frame segmenter: holds the message state and
// turns the held input word into at most one frame byte per step. Uses mfs_pkg.
`default_nettype none

module mfs_core
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         advance,
    input  wire mfs_pkg::item_t               item,
    input  wire logic [mfs_pkg::BYTE_W-1:0]   fill_byte,
    output mfs_pkg::step_t                    step
);

    logic [mfs_pkg::FRAMES_W-1:0] frames_total_reg, frames_total_next;
    logic [mfs_pkg::FRAMES_W-1:0] frame_number_reg, frame_number_next;
    logic [mfs_pkg::POS_W-1:0]    byte_pos_reg, byte_pos_next;
    logic [mfs_pkg::LEN_W-1:0]    bytes_left_reg, bytes_left_next;
    logic                         active_reg, active_next;
    mfs_pkg::phase_t              phase_reg, phase_next;

    logic [mfs_pkg::LEN_W-1:0]    len_sat;
    logic [mfs_pkg::SUM_W-1:0]    len_sum;
    logic [mfs_pkg::FRAMES_W-1:0] frames_new;
    logic                         starting;
    logic [mfs_pkg::POS_W-1:0]    cur_pos;
    logic [mfs_pkg::POS_W:0]      pos_inc;
    logic [mfs_pkg::POS_W-1:0]    pos_wrap;
    logic [mfs_pkg::LEN_W-1:0]    left_dec;
    logic [mfs_pkg::FRAMES_W-1:0] frame_inc;
    logic                         last_frame;
    logic                         next_is_last;

    // Byte idx of the frame count, most significant first, as a 32-bit word.
    function automatic logic [mfs_pkg::BYTE_W-1:0] count_byte(
        input logic [mfs_pkg::FRAMES_W-1:0] total,
        input logic [mfs_pkg::POS_W-1:0]    idx
    );
        logic [mfs_pkg::COUNT_W-1:0] word;
        logic [mfs_pkg::POS_W-1:0]   rank;
        word = mfs_pkg::COUNT_W'(total);
        rank = mfs_pkg::POS_W'(mfs_pkg::COUNT_BYTES - 1) - idx;
        return mfs_pkg::BYTE_W'(word >> (mfs_pkg::BYTE_W * int'(rank)));
    endfunction

    always_comb
    begin
        if ({16'd0, item.message_length} > 32'(mfs_pkg::MAX_MESSAGE_BYTES))
            len_sat = mfs_pkg::LEN_W'(mfs_pkg::MAX_MESSAGE_BYTES);
        else
            len_sat = item.message_length;
        len_sum = mfs_pkg::SUM_W'(len_sat)
                + mfs_pkg::SUM_W'(mfs_pkg::HEADER_BYTES + mfs_pkg::FOOTER_BYTES
                                  + mfs_pkg::FRAME_BYTES - 1);
        if (len_sat <= mfs_pkg::LEN_W'(mfs_pkg::PAYLOAD_CAP))
            frames_new = mfs_pkg::FRAMES_W'(1);
        else
            frames_new = mfs_pkg::FRAMES_W'(len_sum >> mfs_pkg::FRAME_SHIFT);
    end

    // A start word restarts the frame at position zero.
    assign starting = (phase_reg == mfs_pkg::PH_ENTRY) && (item.kind == mfs_pkg::KIND_START);
    assign cur_pos  = starting ? '0 : byte_pos_reg;
    assign pos_inc  = {1'b0, cur_pos} + (mfs_pkg::POS_W+1)'(1);
    assign pos_wrap = (pos_inc >= (mfs_pkg::POS_W+1)'(mfs_pkg::FRAME_BYTES))
                      ? '0 : pos_inc[mfs_pkg::POS_W-1:0];

    assign left_dec     = (bytes_left_reg == '0) ? '0 : bytes_left_reg - 1'b1;
    assign frame_inc    = frame_number_reg + 1'b1;
    assign last_frame   = ({1'b0, frame_number_reg} + 1'b1) >= {1'b0, frames_total_reg};
    assign next_is_last = ({1'b0, frame_inc} + 1'b1) >= {1'b0, frames_total_reg};

    always_comb
    begin
        frames_total_next = frames_total_reg;
        frame_number_next = frame_number_reg;
        byte_pos_next     = byte_pos_reg;
        bytes_left_next   = bytes_left_reg;
        active_next       = active_reg;
        phase_next        = phase_reg;
        step.done         = 1'b0;
        step.emit         = 1'b0;
        step.value        = '0;
        step.eof          = (pos_inc >= (mfs_pkg::POS_W+1)'(mfs_pkg::FRAME_BYTES));

        unique case (phase_reg)
            mfs_pkg::PH_ENTRY:
            begin
                if (item.kind == mfs_pkg::KIND_START)
                begin
                    frames_total_next = frames_new;
                    frame_number_next = '0;
                    bytes_left_next   = len_sat;
                    active_next       = 1'b1;
                    step.emit         = 1'b1;
                    step.value        = count_byte(frames_new, '0);
                    byte_pos_next     = pos_wrap;
                    phase_next        = mfs_pkg::PH_HEADER;
                end
                else if (active_reg)
                begin
                    step.emit       = 1'b1;
                    step.value      = item.data_byte;
                    bytes_left_next = left_dec;
                    byte_pos_next   = pos_wrap;
                    if (last_frame && left_dec == '0)
                    begin
                        active_next = 1'b0;
                        if (pos_wrap != '0)
                            phase_next = mfs_pkg::PH_FILL;
                        else
                            step.done = 1'b1;
                    end
                    else if (pos_wrap == '0)
                    begin
                        frame_number_next = frame_inc;
                        if (next_is_last)
                            phase_next = mfs_pkg::PH_LENGTH;
                        else
                            step.done = 1'b1;
                    end
                    else
                    begin
                        step.done = 1'b1;
                    end
                end
                else
                begin
                    // Data with no message open is dropped without output.
                    step.done = 1'b1;
                end
            end

            mfs_pkg::PH_HEADER:
            begin
                step.emit     = 1'b1;
                byte_pos_next = pos_wrap;
                if (byte_pos_reg < mfs_pkg::POS_W'(mfs_pkg::COUNT_BYTES))
                begin
                    step.value = count_byte(frames_total_reg, byte_pos_reg);
                end
                else
                begin
                    if (bytes_left_reg <= mfs_pkg::LEN_W'(mfs_pkg::PAYLOAD_CAP))
                        step.value = mfs_pkg::BYTE_W'(bytes_left_reg);
                    else
                        step.value = mfs_pkg::BYTE_W'(mfs_pkg::PAYLOAD_CAP);
                    if (frames_total_reg == mfs_pkg::FRAMES_W'(1) && bytes_left_reg == '0)
                    begin
                        active_next = 1'b0;
                        if (pos_wrap != '0)
                            phase_next = mfs_pkg::PH_FILL;
                        else
                            step.done = 1'b1;
                    end
                    else
                    begin
                        step.done = 1'b1;
                    end
                end
            end

            mfs_pkg::PH_LENGTH:
            begin
                step.emit     = 1'b1;
                step.value    = mfs_pkg::BYTE_W'(bytes_left_reg);
                byte_pos_next = pos_wrap;
                if (bytes_left_reg == '0)
                begin
                    active_next = 1'b0;
                    if (pos_wrap != '0)
                        phase_next = mfs_pkg::PH_FILL;
                    else
                        step.done = 1'b1;
                end
                else
                begin
                    step.done = 1'b1;
                end
            end

            mfs_pkg::PH_FILL:
            begin
                step.emit     = 1'b1;
                step.value    = fill_byte;
                byte_pos_next = pos_wrap;
                if (pos_wrap == '0)
                    step.done = 1'b1;
            end

            default:
            begin
                step.done = 1'b1;
            end
        endcase

        if (step.done)
            phase_next = mfs_pkg::PH_ENTRY;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frames_total_reg <= '0;
            frame_number_reg <= '0;
            byte_pos_reg     <= '0;
            bytes_left_reg   <= '0;
            active_reg       <= 1'b0;
            phase_reg        <= mfs_pkg::PH_ENTRY;
        end
        else if (advance)
        begin
            frames_total_reg <= frames_total_next;
            frame_number_reg <= frame_number_next;
            byte_pos_reg     <= byte_pos_next;
            bytes_left_reg   <= bytes_left_next;
            active_reg       <= active_next;
            phase_reg        <= phase_next;
        end
    end

endmodule

`default_nettype wire

### rtl/message_frame_segmenter_top.sv
// Top level of the message frame segmenter: input word register, fill-byte
// register and output byte register around the mfs_core sequencer.
// Depends on mfs_pkg, the channel interfaces in mfs_if.sv and mfs_core.
//
//   Channel   Direction   Word carries                              Accepted when
//   item      in          kind, message_length, data_byte           valid && ready
//   frame     out         frame_byte, end_of_frame, end_of_run      valid && ready
//   cfg       in          fill_byte                                 valid && ready
//
// The block produces at most one frame byte per cycle, a rate that the
// single-byte output register sets. A word yields a run of bytes: a data
// byte in mid-frame yields one, a start word five (32 for an empty message),
// and a data byte that closes a frame up to 33 when a length byte and pad
// follow it. While a run is being produced the item channel is held off,
// and the next word is taken in the cycle in which the last byte of the run
// moves into the output register.
// A stall on the frame channel freezes the sequencer with no byte lost.
// Reset closes any open message and sets the fill byte to 1; cfg is always ready.
`default_nettype none

module message_frame_segmenter_top
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    mfs_item_if.sink       item,
    mfs_frame_if.source    frame,
    mfs_cfg_if.sink        cfg
);

    // Held input word waiting for, or in the middle of, its run of bytes.
    logic                          item_valid_reg;
    mfs_pkg::item_t                item_reg;

    logic [mfs_pkg::BYTE_W-1:0]    fill_reg;

    logic                          out_valid_reg;
    logic [mfs_pkg::BYTE_W-1:0]    out_byte_reg;
    logic                          out_eof_reg;
    logic                          out_eor_reg;

    logic                          out_free;
    logic                          advance;
    logic                          item_take;
    mfs_pkg::step_t                step;

    // The sequencer steps only when the output register can take its byte.
    assign out_free  = !out_valid_reg || frame.ready;
    assign advance   = item_valid_reg && out_free;
    assign item.ready = !item_valid_reg || (advance && step.done);
    assign item_take = item.valid && item.ready;

    assign cfg.ready = 1'b1;

    mfs_core u_core
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .item      (item_reg),
        .fill_byte (fill_reg),
        .step      (step)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else if (item_take)
        begin
            item_valid_reg <= 1'b1;
        end
        else if (advance && step.done)
        begin
            item_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_take)
        begin
            item_reg.kind           <= mfs_pkg::kind_t'(item.kind);
            item_reg.message_length <= item.message_length;
            item_reg.data_byte      <= item.data_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= mfs_pkg::BYTE_W'(1);
        end
        else if (cfg.valid && cfg.ready)
        begin
            fill_reg <= cfg.fill_byte;
        end
    end

    // Output register: the end of run flag marks the byte that finishes a word.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance && step.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (frame.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && step.emit)
        begin
            out_byte_reg <= step.value;
            out_eof_reg  <= step.eof;
            out_eor_reg  <= step.done;
        end
    end

    assign frame.valid        = out_valid_reg;
    assign frame.frame_byte   = out_byte_reg;
    assign frame.end_of_frame = out_eof_reg;
    assign frame.end_of_run   = out_eor_reg;

endmodule

`default_nettype wire
